// ===== hdl/pgb_pkg.sv =====
// pgb_pkg: shared constants, codes, types and helpers of the partition gain bucket
// used by every file of the block; depends on nothing
`default_nettype none

package pgb_pkg;

	// sizing of the vertex store
	localparam int NUM_VERTICES = 1024;
	localparam int MAX_GAIN     = 64;
	localparam int IDX_W        = $clog2(NUM_VERTICES);

	// field widths of the request and result channels
	localparam int MODE_W = 2;
	localparam int VTX_W  = 10;
	localparam int GAIN_W = 8;
	localparam int BAL_W  = 12;

	// configuration port
	localparam int TOL_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// internal widths
	localparam int SGAIN_W = $clog2(MAX_GAIN + 1) + 1;
	localparam int SUM_W   = ((SGAIN_W > GAIN_W) ? SGAIN_W : GAIN_W) + 1;
	localparam int STAMP_W = 32;

	// request codes
	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_POP    = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIFO_ORDER  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_TOL = 1'b1;

	// one vertex entry of the store
	typedef struct packed {
		logic                      present;
		logic                      locked;
		logic                      side;
		logic signed [SGAIN_W-1:0] gain;
		logic [STAMP_W-1:0]        stamp;
	} entry_t;

	// write request into the store
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} ram_wr_t;

	// one scanned entry handed to the compare unit
	typedef struct packed {
		logic                      present;
		logic                      side;
		logic [IDX_W-1:0]          idx;
		logic signed [SGAIN_W-1:0] gain;
		logic [STAMP_W-1:0]        age;
	} cand_t;

	// best entry found so far on one side
	typedef struct packed {
		logic                      found;
		logic [IDX_W-1:0]          idx;
		logic signed [SGAIN_W-1:0] gain;
		logic [STAMP_W-1:0]        age;
	} best_t;

	typedef struct packed {
		best_t l;
		best_t r;
	} best_pair_t;

	// saturate a gain to plus or minus the maximum gain
	function automatic logic signed [SGAIN_W-1:0] clamp_gain(input logic signed [SUM_W-1:0] g);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(MAX_GAIN);
		lo = -hi;
		if (g > hi) begin
			return SGAIN_W'(hi);
		end else if (g < lo) begin
			return SGAIN_W'(lo);
		end
		return SGAIN_W'(g);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pgb_if.sv =====
// pgb_cmd_if and pgb_res_if: valid/ready channels of the partition gain bucket
// depends on pgb_pkg for field widths
`default_nettype none

interface pgb_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [pgb_pkg::MODE_W-1:0]        mode;
	logic [pgb_pkg::VTX_W-1:0]         vertex;
	logic                              side;
	logic signed [pgb_pkg::GAIN_W-1:0] gain_value;
	logic signed [pgb_pkg::BAL_W-1:0]  balance;

	modport source (output valid, mode, vertex, side, gain_value, balance, input ready);
	modport sink (input valid, mode, vertex, side, gain_value, balance, output ready);
endinterface

interface pgb_res_if;
	logic                              valid;
	logic                              ready;
	logic [pgb_pkg::VTX_W-1:0]         moved_vertex;
	logic signed [pgb_pkg::GAIN_W-1:0] moved_gain;
	logic                              moved_side;
	logic                              no_move;

	modport source (output valid, moved_vertex, moved_gain, moved_side, no_move, input ready);
	modport sink (input valid, moved_vertex, moved_gain, moved_side, no_move, output ready);
endinterface

`default_nettype wire

// ===== hdl/partition_gain_bucket.sv =====
// Partition gain bucket: holds side, gain, present/locked flags and an insertion
// stamp for every vertex in one single-port-read store. A load writes its entry and
// then delivers its result, update and remove first go through read, modify and
// write, and the next request can be taken as soon as the result appears. Pop walks
// the whole store one entry per cycle through the read port and a shared gain/age
// compare unit, drains the scan pipeline, picks a vertex and then delivers its result.
// After reset a clearing pass writes every entry before the first request is
// taken; configuration writes are taken at any time. A result may wait on the
// output while the next request is already accepted; that request finishes only
// once the waiting result is taken.
// depends on pgb_pkg, pgb_if, pgb_vtx_ram and pgb_best
`default_nettype none

module partition_gain_bucket (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	pgb_cmd_if.sink                                  cmd,
	pgb_res_if.source                                res,
	input  wire logic                                cfg_we,
	input  wire logic [pgb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pgb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int IDX_W   = pgb_pkg::IDX_W;
	localparam int SUM_W   = pgb_pkg::SUM_W;
	localparam int BAL_W   = pgb_pkg::BAL_W;
	localparam int STAMP_W = pgb_pkg::STAMP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(pgb_pkg::NUM_VERTICES - 1);

	typedef enum logic [9:0] {
		ST_CLEAR  = 10'b00_0000_0001,
		ST_IDLE   = 10'b00_0000_0010,
		ST_LOAD   = 10'b00_0000_0100,
		ST_READ   = 10'b00_0000_1000,
		ST_MODIFY = 10'b00_0001_0000,
		ST_SCAN   = 10'b00_0010_0000,
		ST_DRAIN  = 10'b00_0100_0000,
		ST_PICK   = 10'b00_1000_0000,
		ST_DONE   = 10'b01_0000_0000,
		ST_SPARE  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic                       fifo_q;
	logic [pgb_pkg::TOL_W-1:0]  tol_q;

	// captured request
	pgb_pkg::mode_t                    op_q;
	logic [IDX_W-1:0]                  vtx_q;
	logic                              ok_q;
	logic                              side_q;
	logic signed [pgb_pkg::GAIN_W-1:0] gval_q;
	logic signed [BAL_W-1:0]           bal_q;

	logic [STAMP_W-1:0] stamp_q;
	logic [IDX_W-1:0]   cnt_q;

	// scan pipeline
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s2;
	pgb_pkg::cand_t   cand_s2;

	// pending and delivered result
	logic [pgb_pkg::VTX_W-1:0]         pend_vertex_q;
	logic signed [pgb_pkg::GAIN_W-1:0] pend_gain_q;
	logic                              pend_side_q;
	logic                              pend_no_move_q;
	logic                              out_valid_q;
	logic [pgb_pkg::VTX_W-1:0]         out_vertex_q;
	logic signed [pgb_pkg::GAIN_W-1:0] out_gain_q;
	logic                              out_side_q;
	logic                              out_no_move_q;

	pgb_pkg::ram_wr_t    ram_wr;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	pgb_pkg::entry_t     ram_rd;
	pgb_pkg::best_pair_t bp;
	logic                best_clr;

	logic                    left_lower;
	logic signed [BAL_W+1:0] bal_x;
	logic signed [BAL_W+1:0] nbal_x;
	logic signed [BAL_W+1:0] tol_x;
	logic                    pick_right;
	pgb_pkg::best_t          pick;
	logic                    cmd_take;
	logic                    stamp_inc;

	pgb_vtx_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rd)
	);

	pgb_best u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (best_clr),
		.fifo_order (fifo_q),
		.en         (vld_s2),
		.cand       (cand_s2),
		.best       (bp)
	);

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && (state_q == ST_IDLE);
	assign best_clr  = cmd_take && (pgb_pkg::mode_t'(cmd.mode) == pgb_pkg::MODE_POP);

	// side choice by the balance rule; an empty side ranks below any gain
	always_comb begin
		left_lower = bp.r.found && (!bp.l.found || (bp.l.gain < bp.r.gain));
		bal_x      = (BAL_W+2)'(bal_q);
		nbal_x     = -bal_x;
		tol_x      = $signed((BAL_W+2)'(tol_q));
		pick_right = (left_lower && (nbal_x < tol_x)) || (bal_x >= tol_x);
		pick       = pick_right ? bp.r : bp.l;
	end

	// store access per state
	always_comb begin
		ram_wr    = '0;
		ram_re    = 1'b0;
		ram_raddr = cnt_q;
		stamp_inc = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_wr.we   = 1'b1;
				ram_wr.addr = cnt_q;
			end
			ST_LOAD: begin
				ram_wr.we   = ok_q;
				ram_wr.addr = vtx_q;
				ram_wr.data = '{present: 1'b1, locked: 1'b0, side: side_q,
					gain: pgb_pkg::clamp_gain(SUM_W'(gval_q)), stamp: stamp_q};
				stamp_inc   = ok_q;
			end
			ST_READ: begin
				ram_re    = 1'b1;
				ram_raddr = vtx_q;
			end
			ST_MODIFY: begin
				ram_wr.addr = vtx_q;
				if (op_q == pgb_pkg::MODE_UPDATE) begin
					ram_wr.we   = ok_q && ram_rd.present && !ram_rd.locked;
					ram_wr.data = '{present: 1'b1, locked: 1'b0, side: side_q,
						gain: pgb_pkg::clamp_gain(SUM_W'(ram_rd.gain) + SUM_W'(gval_q)),
						stamp: stamp_q};
					stamp_inc   = ram_wr.we;
				end else begin
					ram_wr.we           = ok_q && !ram_rd.locked;
					ram_wr.data         = ram_rd;
					ram_wr.data.present = 1'b0;
				end
			end
			ST_SCAN: begin
				ram_re = 1'b1;
			end
			ST_PICK: begin
				ram_wr.we   = pick.found;
				ram_wr.addr = pick.idx;
				ram_wr.data = '{present: 1'b0, locked: 1'b1, side: pick_right,
					gain: pick.gain, stamp: '0};
			end
			default: begin
			end
		endcase
	end

	// scan pipeline: read data, then age against the current stamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1          <= cnt_q;
		cand_s2.present <= ram_rd.present;
		cand_s2.side    <= ram_rd.side;
		cand_s2.idx     <= idx_s1;
		cand_s2.gain    <= ram_rd.gain;
		cand_s2.age     <= stamp_q - ram_rd.stamp;
	end

	// sequencer, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			stamp_q     <= '0;
			fifo_q      <= 1'b0;
			tol_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pgb_pkg::REG_FIFO_ORDER:  fifo_q <= cfg_data[0];
					pgb_pkg::REG_BALANCE_TOL: tol_q  <= cfg_data[pgb_pkg::TOL_W-1:0];
					default: begin
					end
				endcase
			end
			if (stamp_inc) begin
				stamp_q <= stamp_q + 1'b1;
			end
			// result valid: set when a result is delivered, cleared once taken
			if ((state_q == ST_DONE) && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						unique case (pgb_pkg::mode_t'(cmd.mode))
							pgb_pkg::MODE_LOAD:   state_q <= ST_LOAD;
							pgb_pkg::MODE_UPDATE: state_q <= ST_READ;
							pgb_pkg::MODE_REMOVE: state_q <= ST_READ;
							pgb_pkg::MODE_POP:    state_q <= ST_SCAN;
							default:              state_q <= ST_IDLE;
						endcase
						cnt_q <= '0;
					end
				end
				ST_LOAD:   state_q <= ST_DONE;
				ST_READ:   state_q <= ST_MODIFY;
				ST_MODIFY: state_q <= ST_DONE;
				ST_SCAN: begin
					cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || res.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture, pending result and output payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q           <= pgb_pkg::mode_t'(cmd.mode);
			vtx_q          <= IDX_W'(cmd.vertex);
			ok_q           <= (32'(cmd.vertex) < pgb_pkg::NUM_VERTICES);
			side_q         <= cmd.side;
			gval_q         <= cmd.gain_value;
			bal_q          <= cmd.balance;
			pend_vertex_q  <= '0;
			pend_gain_q    <= '0;
			pend_side_q    <= 1'b0;
			pend_no_move_q <= 1'b0;
		end
		if (state_q == ST_PICK) begin
			pend_vertex_q  <= pick.found ? pgb_pkg::VTX_W'(pick.idx) : '0;
			pend_gain_q    <= pick.found ? pgb_pkg::GAIN_W'(pick.gain) : '0;
			pend_side_q    <= pick_right;
			pend_no_move_q <= !pick.found;
		end
		if ((state_q == ST_DONE) && (!out_valid_q || res.ready)) begin
			out_vertex_q  <= pend_vertex_q;
			out_gain_q    <= pend_gain_q;
			out_side_q    <= pend_side_q;
			out_no_move_q <= pend_no_move_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.moved_vertex = out_vertex_q;
	assign res.moved_gain   = out_gain_q;
	assign res.moved_side   = out_side_q;
	assign res.no_move      = out_no_move_q;

`ifndef NO_ASSERTIONS
	// the store is not written while a pop walks it
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !ram_wr.we)
		else $error("store written during pop scan");

	// the pick happens only after the scan pipeline has drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> (!vld_s1 && !vld_s2))
		else $error("pick with entries still in the scan pipeline");

	// the stamp advances only when load or update places a vertex
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(stamp_q) |-> ($past(state_q) == ST_LOAD || $past(state_q) == ST_MODIFY))
		else $error("stamp advanced outside load or update");

	// a found vertex never reports no_move
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK && pick.found) |=> !pend_no_move_q)
		else $error("no_move set although a vertex was picked");

	// a pending result never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready) |=> $stable(out_vertex_q) && $stable(out_no_move_q))
		else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire

// ===== hdl/pgb_vtx_ram.sv =====
// pgb_vtx_ram: vertex entry store, one write port and one registered read port
// depends on pgb_pkg for the entry and write types
`default_nettype none

module pgb_vtx_ram (
	input  wire logic                          clk,
	input  wire pgb_pkg::ram_wr_t              wr,
	input  wire logic                          re,
	input  wire logic [pgb_pkg::IDX_W-1:0]     raddr,
	output pgb_pkg::entry_t                    rdata
);

	pgb_pkg::entry_t mem [pgb_pkg::NUM_VERTICES];
	pgb_pkg::entry_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/pgb_best.sv =====
// pgb_best: shared compare unit that keeps the best entry of each side during a scan
// depends on pgb_pkg for the candidate and best types
`default_nettype none

module pgb_best (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                clr,
	input  wire logic                fifo_order,
	input  wire logic                en,
	input  wire pgb_pkg::cand_t      cand,
	output pgb_pkg::best_pair_t      best
);

	pgb_pkg::best_t l_q;
	pgb_pkg::best_t r_q;
	pgb_pkg::best_t cur;
	logic           gain_gt;
	logic           gain_eq;
	logic           age_better;
	logic           take;
	pgb_pkg::best_t nxt;

	// compare the incoming entry against the best of its own side
	always_comb begin
		cur        = cand.side ? r_q : l_q;
		gain_gt    = cand.gain > cur.gain;
		gain_eq    = cand.gain == cur.gain;
		age_better = fifo_order ? (cand.age > cur.age) : (cand.age < cur.age);
		take       = en && cand.present &&
			(!cur.found || gain_gt || (gain_eq && age_better));
		nxt        = '{found: 1'b1, idx: cand.idx, gain: cand.gain, age: cand.age};
	end

	// per-side best registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q <= '0;
			r_q <= '0;
		end else if (clr) begin
			l_q.found <= 1'b0;
			r_q.found <= 1'b0;
		end else if (take) begin
			if (cand.side) begin
				r_q <= nxt;
			end else begin
				l_q <= nxt;
			end
		end
	end

	assign best = '{l: l_q, r: r_q};

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: sends load, update, remove and pop requests into partition_gain_bucket
// under changing idle patterns and checks every move against a shadow vertex store
// depends on pgb_pkg, pgb_if and the partition_gain_bucket rtl
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pgb_pkg::*;

	typedef struct {
		mode_t                     mode;
		logic [VTX_W-1:0]          vertex;
		logic                      side;
		logic signed [GAIN_W-1:0]  gain_value;
		logic signed [BAL_W-1:0]   balance;
	} request_t;

	typedef struct {
		logic [VTX_W-1:0]          moved_vertex;
		logic signed [GAIN_W-1:0]  moved_gain;
		logic                      moved_side;
		logic                      no_move;
	} move_t;

	// shadow copy of the vertex store; predicts the move of each request
	class bucket_mirror;
		int               v_gain[NUM_VERTICES];
		bit               v_side[NUM_VERTICES];
		bit               v_in_bucket[NUM_VERTICES];
		bit               v_frozen[NUM_VERTICES];
		bit [STAMP_W-1:0] v_mark[NUM_VERTICES];
		bit [STAMP_W-1:0] next_mark;
		bit               oldest_first;
		int               tolerance;
		move_t            awaited_moves[$];
		int               failures;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FIFO_ORDER) begin
				oldest_first = data[0];
			end else begin
				tolerance = int'(data[TOL_W-1:0]);
			end
		endfunction

		function int saturate(int g);
			if (g > MAX_GAIN) return MAX_GAIN;
			if (g < -MAX_GAIN) return -MAX_GAIN;
			return g;
		endfunction

		function void insert_vertex(int v, bit s, int g);
			v_gain[v] = saturate(g);
			v_side[v] = s;
			v_in_bucket[v] = 1'b1;
			v_mark[v] = next_mark;
			next_mark = next_mark + 1;
		endfunction

		// highest gain of one side, ties broken by age; -1 when the side is empty
		function int top_of_side(bit s);
			int best;
			bit [STAMP_W-1:0] best_age;
			bit [STAMP_W-1:0] age;
			best = -1;
			best_age = '0;
			for (int v = 0; v < NUM_VERTICES; v++) begin
				if (v_in_bucket[v] && v_side[v] == s) begin
					age = next_mark - v_mark[v];
					if (best < 0 || v_gain[v] > v_gain[best]) begin
						best = v;
						best_age = age;
					end else if (v_gain[v] == v_gain[best] &&
							(oldest_first ? age > best_age : age < best_age)) begin
						best = v;
						best_age = age;
					end
				end
			end
			return best;
		endfunction

		// apply one accepted request and queue the move it predicts
		function void take_request(request_t r);
			move_t m;
			int v;
			int bal;
			int left_top;
			int right_top;
			int pick;
			bit left_lower;
			bit go_right;
			m = '{default: '0};
			v = int'(r.vertex);
			case (r.mode)
				MODE_LOAD: begin
					v_frozen[v] = 1'b0;
					insert_vertex(v, r.side, int'(r.gain_value));
				end
				MODE_UPDATE: begin
					if (!v_frozen[v] && v_in_bucket[v]) begin
						insert_vertex(v, r.side, v_gain[v] + int'(r.gain_value));
					end
				end
				MODE_REMOVE: begin
					if (!v_frozen[v]) v_in_bucket[v] = 1'b0;
				end
				MODE_POP: begin
					left_top = top_of_side(1'b0);
					right_top = top_of_side(1'b1);
					bal = int'(r.balance);
					// an empty side ranks below any gain
					if (right_top < 0) begin
						left_lower = 1'b0;
					end else if (left_top < 0) begin
						left_lower = 1'b1;
					end else begin
						left_lower = v_gain[left_top] < v_gain[right_top];
					end
					go_right = (left_lower && -bal < tolerance) || bal >= tolerance;
					pick = go_right ? right_top : left_top;
					m.moved_side = go_right;
					if (pick < 0) begin
						m.no_move = 1'b1;
					end else begin
						v_in_bucket[pick] = 1'b0;
						v_frozen[pick] = 1'b1;
						m.moved_vertex = VTX_W'(pick);
						m.moved_gain = GAIN_W'(v_gain[pick]);
					end
				end
			endcase
			awaited_moves.insert(awaited_moves.size(), m);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10) $display("%0t: %s", $time, msg);
		endfunction

		// compare one accepted move with the oldest prediction
		function void check_move(move_t got);
			move_t want;
			if (awaited_moves.size() == 0) begin
				note_failure($sformatf("move with none awaited: vertex=%0d gain=%0d side=%0d no_move=%0d",
					got.moved_vertex, got.moved_gain, got.moved_side, got.no_move));
				return;
			end
			want = awaited_moves[0];
			awaited_moves.delete(0);
			if (got.moved_vertex !== want.moved_vertex || got.moved_gain !== want.moved_gain ||
					got.moved_side !== want.moved_side || got.no_move !== want.no_move) begin
				note_failure($sformatf({"move mismatch: expected vertex=%0d gain=%0d side=%0d ",
					"no_move=%0d, got vertex=%0d gain=%0d side=%0d no_move=%0d"},
					want.moved_vertex, want.moved_gain, want.moved_side, want.no_move,
					got.moved_vertex, got.moved_gain, got.moved_side, got.no_move));
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  hold_off;

	int send_idle_pct;
	int recv_stall_pct;
	int cur_tol;

	bucket_mirror shadow = new;

	pgb_cmd_if cmd_ch ();
	pgb_res_if res_ch ();

	partition_gain_bucket dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#40ms;
		$display("[partition_gain_bucket] ERROR");
		$finish;
	end

	// result side: check each accepted move, then choose the next ready
	initial begin
		move_t got;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				got.moved_vertex = res_ch.moved_vertex;
				got.moved_gain = res_ch.moved_gain;
				got.moved_side = res_ch.moved_side;
				got.no_move = res_ch.no_move;
				shadow.check_move(got);
			end
			res_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic int random_gap();
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
		return gap;
	endfunction

	// random request on a small vertex pool so buckets fill and collide
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			r.mode = MODE_LOAD;
		end else if (pick < 60) begin
			r.mode = MODE_UPDATE;
		end else if (pick < 75) begin
			r.mode = MODE_REMOVE;
		end else begin
			r.mode = MODE_POP;
		end
		if ($urandom_range(0, 9) == 0) begin
			r.vertex = VTX_W'($urandom_range(0, NUM_VERTICES - 1));
		end else begin
			r.vertex = VTX_W'($urandom_range(0, 23));
		end
		r.side = 1'($urandom);
		if ($urandom_range(0, 6) == 0) begin
			r.gain_value = GAIN_W'($urandom);
		end else begin
			r.gain_value = GAIN_W'(int'($urandom_range(0, 2 * MAX_GAIN)) - MAX_GAIN);
		end
		// balance half the time near the tolerance edges
		case ($urandom_range(0, 3))
			0: r.balance = BAL_W'(cur_tol + int'($urandom_range(0, 4)) - 2);
			1: r.balance = BAL_W'(-cur_tol + int'($urandom_range(0, 4)) - 2);
			2: r.balance = BAL_W'(int'($urandom_range(0, 128)) - 64);
			default: r.balance = BAL_W'($urandom);
		endcase
		return r;
	endfunction

	// offer one request after an optional gap and wait for it to be taken
	task automatic send_request(request_t r, int gap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= r.mode;
		cmd_ch.vertex <= r.vertex;
		cmd_ch.side <= r.side;
		cmd_ch.gain_value <= r.gain_value;
		cmd_ch.balance <= r.balance;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		shadow.take_request(r);
	endtask

	task automatic send_op(mode_t mode, int vertex, bit side, int gain, int bal);
		request_t r;
		r.mode = mode;
		r.vertex = VTX_W'(vertex);
		r.side = side;
		r.gain_value = GAIN_W'(gain);
		r.balance = BAL_W'(bal);
		send_request(r, 0);
	endtask

	// stop sending and wait until every predicted move has come back
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (shadow.awaited_moves.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(bit oldest, int tol);
		cfg_we <= 1'b1;
		cfg_index <= REG_FIFO_ORDER;
		cfg_data <= CFG_DATA_W'(oldest);
		@(posedge clk);
		shadow.set_reg(REG_FIFO_ORDER, CFG_DATA_W'(oldest));
		cfg_index <= REG_BALANCE_TOL;
		cfg_data <= CFG_DATA_W'(tol);
		@(posedge clk);
		shadow.set_reg(REG_BALANCE_TOL, CFG_DATA_W'(tol));
		cfg_we <= 1'b0;
		cur_tol = tol;
	endtask

	task automatic run_phase(int target);
		repeat (target) send_request(random_request(), random_gap());
		settle();
	endtask

	// keep the result side stalled long enough for requests to back up
	task automatic hold_results(int cycles);
		hold_off <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.mode <= MODE_LOAD;
		cmd_ch.vertex <= '0;
		cmd_ch.side <= 1'b0;
		cmd_ch.gain_value <= '0;
		cmd_ch.balance <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FIFO_ORDER;
		cfg_data <= '0;
		hold_off <= 1'b0;
		arst_n <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_tol = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_regs(1'b0, 0);

		// directed: empty store, saturation, ignored requests, ties, both sides
		send_op(MODE_POP, 0, 1'b0, 0, 0);
		send_op(MODE_LOAD, 0, 1'b0, 127, 0);
		send_op(MODE_LOAD, 1023, 1'b1, -128, 0);
		send_op(MODE_LOAD, 5, 1'b0, 64, 0);
		send_op(MODE_LOAD, 6, 1'b0, 64, 0);
		send_op(MODE_UPDATE, 1023, 1'b1, -128, 0);
		send_op(MODE_UPDATE, 7, 1'b0, 5, 0);
		send_op(MODE_REMOVE, 8, 1'b0, 0, 0);
		send_op(MODE_POP, 0, 1'b0, 0, -2048);
		send_op(MODE_UPDATE, 6, 1'b0, 1, 0);
		send_op(MODE_REMOVE, 6, 1'b0, 0, 0);
		send_op(MODE_LOAD, 6, 1'b1, -1, 0);
		send_op(MODE_UPDATE, 0, 1'b1, 127, 0);
		send_op(MODE_POP, 0, 1'b0, 0, 2047);
		send_op(MODE_REMOVE, 5, 1'b0, 0, 0);
		send_op(MODE_POP, 0, 1'b0, 0, -1);
		send_op(MODE_UPDATE, 1023, 1'b0, 127, 0);
		send_op(MODE_UPDATE, 1023, 1'b0, 127, 0);
		send_op(MODE_UPDATE, 6, 1'b1, -128, 0);
		send_op(MODE_POP, 0, 1'b0, 0, 0);
		send_op(MODE_POP, 0, 1'b0, 0, 0);
		send_op(MODE_POP, 0, 1'b0, 0, -2048);
		settle();

		// random phases, each with its own register setting and idle pattern
		write_regs(1'b0, 0);
		run_phase(160);

		write_regs(1'b1, 2047);
		send_idle_pct = 46;
		run_phase(160);

		write_regs(1'b1, 3);
		send_idle_pct = 0;
		recv_stall_pct = 46;
		run_phase(160);

		write_regs(1'b0, 1024);
		send_idle_pct = 37;
		recv_stall_pct = 37;
		run_phase(160);

		write_regs(1'b1, 0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			hold_results(3000);
			run_phase(160);
		join

		repeat (64) @(posedge clk);
		if (shadow.failures == 0 && shadow.awaited_moves.size() == 0) begin
			$display("[partition_gain_bucket] OK");
		end else begin
			$display("[partition_gain_bucket] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== partition_gain_bucket.f =====
hdl/pgb_pkg.sv
hdl/pgb_if.sv
hdl/pgb_vtx_ram.sv
hdl/pgb_best.sv
hdl/partition_gain_bucket.sv
tb/sv/testbench.sv
